// ===== hdl/equirect_to_perspective_map_macros.svh =====
// Assertion macros shared by the equirectangular map RTL.
`ifndef EQUIRECT_TO_PERSPECTIVE_MAP_MACROS_SVH
`define EQUIRECT_TO_PERSPECTIVE_MAP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define E2P_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define E2P_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/e2p_pkg.sv =====
// Constants, register codes and tables of the equirectangular map.
package e2p_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int DIM_BITS   = 13;
  localparam int FOCAL_BITS = 24;
  localparam int COEF_BITS  = 18;
  localparam int ROW_BITS   = 3 * COEF_BITS;
  localparam int CFG_IDX_BITS = 3;

  localparam int IN_TDATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 24;
  localparam int OUT_TDATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(512);
  localparam logic [FOCAL_BITS-1:0] FOCAL_RESET  = FOCAL_BITS'(131072);
  localparam logic [COEF_BITS-1:0]  COEF_ONE     = COEF_BITS'(65536);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_FOCAL_LENGTH = 3'd2,
    CFG_ROT_ROW0     = 3'd3,
    CFG_ROT_ROW1     = 3'd4,
    CFG_ROT_ROW2     = 3'd5
  } cfg_idx_e;

  // Phase: 16-bit fraction of a turn.
  localparam int PHASE_BITS   = 16;
  localparam int TURN_HALF    = 32768;
  localparam int TURN_QUARTER = 16384;

  // Phase divider: numerator |2p - size| * 2^k + size, divisor 2 * size.
  localparam int DIFF_BITS   = ((COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS) + 1;
  localparam int PH_MAG_BITS = DIFF_BITS - 1;
  localparam int PH_NB       = PH_MAG_BITS + PHASE_BITS + 1;
  localparam int PH_DW       = DIM_BITS + 2;

  // CORDIC datapath.
  localparam int ANG_BITS        = 18;
  localparam int CORDIC_STEPS    = 14;
  localparam int CORDIC_GAIN_INV = 39797;

  // Ray, rotation and projection.
  localparam int RAY_BITS  = 18;
  localparam int PROD_BITS = COEF_BITS + RAY_BITS;
  localparam int ROT_BITS  = PROD_BITS + 2;
  localparam int PMUL_BITS = ROT_BITS + FOCAL_BITS;
  localparam int PJ_NB     = PMUL_BITS + 2;
  localparam int PJ_DW     = ROT_BITS + 1;
  localparam int PJ_QB     = 30;
  localparam int SUM_BITS  = PJ_QB + 2;

  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  function automatic logic signed [ANG_BITS-1:0] atan_turn(input int step);
    logic signed [ANG_BITS-1:0] a;
    case (step)
      0:       a = ANG_BITS'(8192);
      1:       a = ANG_BITS'(4836);
      2:       a = ANG_BITS'(2555);
      3:       a = ANG_BITS'(1297);
      4:       a = ANG_BITS'(651);
      5:       a = ANG_BITS'(326);
      6:       a = ANG_BITS'(163);
      7:       a = ANG_BITS'(81);
      8:       a = ANG_BITS'(41);
      9:       a = ANG_BITS'(20);
      10:      a = ANG_BITS'(10);
      11:      a = ANG_BITS'(5);
      12:      a = ANG_BITS'(3);
      13:      a = ANG_BITS'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/equirect_to_perspective_map.sv =====
// Pipelined equirectangular to perspective source coordinate map.
// One item per cycle is taken while the output is not stalled.
// The pipeline is the 30-step phase divider, the 14-step CORDIC and the 30-step projection
// divider, each one register stage per step, plus register stages of input, multiply and setup.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears all valid bits and loads the default registers (identity rotation).
`include "equirect_to_perspective_map_macros.svh"

module equirect_to_perspective_map (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // pixel_x, pixel_y
  input  logic [e2p_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // source_x, source_y
  output logic [e2p_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // in_front
  output logic [0:0] m_axis_tuser,
  input  logic cfg_we_i,
  input  logic [e2p_pkg::CFG_IDX_BITS-1:0] cfg_addr_i,
  input  logic [e2p_pkg::ROW_BITS-1:0] cfg_wdata_i
);

  localparam int CB    = e2p_pkg::COORD_BITS;
  localparam int DB    = e2p_pkg::DIM_BITS;
  localparam int PH_NB = e2p_pkg::PH_NB;
  localparam int PH_DW = e2p_pkg::PH_DW;
  localparam int PH_MB = e2p_pkg::PH_MAG_BITS;
  localparam int DFB   = e2p_pkg::DIFF_BITS;
  localparam int PB    = e2p_pkg::PHASE_BITS;
  localparam int AB    = e2p_pkg::ANG_BITS;
  localparam int NCS   = e2p_pkg::CORDIC_STEPS;
  localparam int RB    = e2p_pkg::RAY_BITS;
  localparam int KB    = e2p_pkg::COEF_BITS;
  localparam int PRB   = e2p_pkg::PROD_BITS;
  localparam int ROB   = e2p_pkg::ROT_BITS;
  localparam int PMB   = e2p_pkg::PMUL_BITS;
  localparam int PJ_NB = e2p_pkg::PJ_NB;
  localparam int PJ_DW = e2p_pkg::PJ_DW;
  localparam int PJ_QB = e2p_pkg::PJ_QB;
  localparam int SB    = e2p_pkg::SUM_BITS;
  localparam int OB    = e2p_pkg::OUT_BITS;

  // Stage numbers along the pipeline.
  localparam int S_PH  = 1;
  localparam int S_CI  = S_PH + PH_NB + 1;
  localparam int S_PP  = S_CI + NCS + 5;
  localparam int S_OUT = S_PP + 3 + PJ_QB;
  localparam int NST   = S_OUT + 1;

  // ---------------------------------------------------------------- config
  logic [DB-1:0]                    width_q, height_q;
  logic [e2p_pkg::FOCAL_BITS-1:0]   focal_q;
  logic [e2p_pkg::ROW_BITS-1:0]     rot_row_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= e2p_pkg::WIDTH_RESET;
      height_q     <= e2p_pkg::HEIGHT_RESET;
      focal_q      <= e2p_pkg::FOCAL_RESET;
      rot_row_q[0] <= e2p_pkg::ROW_BITS'(e2p_pkg::COEF_ONE);
      rot_row_q[1] <= e2p_pkg::ROW_BITS'(e2p_pkg::COEF_ONE) << KB;
      rot_row_q[2] <= e2p_pkg::ROW_BITS'(e2p_pkg::COEF_ONE) << (2 * KB);
    end else if (cfg_we_i) begin
      case (e2p_pkg::cfg_idx_e'(cfg_addr_i))
        e2p_pkg::CFG_IMAGE_WIDTH:  width_q      <= cfg_wdata_i[DB-1:0];
        e2p_pkg::CFG_IMAGE_HEIGHT: height_q     <= cfg_wdata_i[DB-1:0];
        e2p_pkg::CFG_FOCAL_LENGTH: focal_q      <= cfg_wdata_i[e2p_pkg::FOCAL_BITS-1:0];
        e2p_pkg::CFG_ROT_ROW0:     rot_row_q[0] <= cfg_wdata_i;
        e2p_pkg::CFG_ROT_ROW1:     rot_row_q[1] <= cfg_wdata_i;
        e2p_pkg::CFG_ROT_ROW2:     rot_row_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // A size of zero acts as one.
  logic [DB-1:0] size [2];
  assign size[0] = (width_q  == '0) ? DB'(1) : width_q;
  assign size[1] = (height_q == '0) ? DB'(1) : height_q;

  // ---------------------------------------------------------------- control
  logic           en;
  logic [NST-1:0] vld_q, vld_d;

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign vld_d         = {vld_q[NST-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------- input
  logic [CB-1:0] pix_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_q[0] <= s_axis_tdata[CB-1:0];
      pix_q[1] <= s_axis_tdata[2*CB-1:CB];
    end
  end

  // ---------------------------------------------------------------- phase divider
  logic [PH_DW-1:0] ph_rem_q [2][PH_NB+1];
  logic [PH_NB-1:0] ph_wrk_q [2][PH_NB+1];
  logic [PH_DW-1:0] ph_den_q [2][PH_NB+1];
  logic             ph_neg_q [2][PH_NB+1];

  for (genvar l = 0; l < 2; l++) begin : g_ph_lane
    logic signed [DFB-1:0] diff;
    logic [PH_MB-1:0]      mag;
    logic [PH_NB-1:0]      num;

    // Longitude spans a full turn, latitude half a turn.
    assign diff = $signed({1'b0, pix_q[l], 1'b0}) - $signed(DFB'(size[l]));
    assign mag  = diff[DFB-1] ? PH_MB'(-diff) : PH_MB'(diff);
    assign num  = (PH_NB'(mag) << (PB - l)) + PH_NB'(size[l]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        ph_rem_q[l][0] <= '0;
        ph_wrk_q[l][0] <= num;
        ph_den_q[l][0] <= {size[l], 1'b0};
        ph_neg_q[l][0] <= diff[DFB-1];
      end
    end

    for (genvar j = 1; j <= PH_NB; j++) begin : g_step
      logic [PH_DW:0] t, dif;
      logic           ge;
      assign t   = {ph_rem_q[l][j-1], ph_wrk_q[l][j-1][PH_NB-1]};
      assign dif = t - {1'b0, ph_den_q[l][j-1]};
      assign ge  = t >= {1'b0, ph_den_q[l][j-1]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          ph_rem_q[l][j] <= ge ? dif[PH_DW-1:0] : t[PH_DW-1:0];
          ph_wrk_q[l][j] <= {ph_wrk_q[l][j-1][PH_NB-2:0], ge};
          ph_den_q[l][j] <= ph_den_q[l][j-1];
          ph_neg_q[l][j] <= ph_neg_q[l][j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- CORDIC
  logic signed [AB-1:0] cx_q [2][NCS+1];
  logic signed [AB-1:0] cy_q [2][NCS+1];
  logic signed [AB-1:0] cz_q [2][NCS+1];
  logic                 cn_q [2][NCS+1];
  logic signed [RB-1:0] sin_q [2];
  logic signed [RB-1:0] cos_q [2];

  for (genvar l = 0; l < 2; l++) begin : g_cordic
    logic signed [PB-1:0] ph;
    assign ph = ph_neg_q[l][PH_NB] ? PB'(-ph_wrk_q[l][PH_NB][PB-1:0])
                                   : ph_wrk_q[l][PH_NB][PB-1:0];

    // Beyond a quarter turn, fold by half a turn and negate the results.
    always_ff @(posedge clk_i) begin
      if (en) begin
        cx_q[l][0] <= AB'(e2p_pkg::CORDIC_GAIN_INV);
        cy_q[l][0] <= '0;
        if (ph > e2p_pkg::TURN_QUARTER) begin
          cz_q[l][0] <= AB'(ph - e2p_pkg::TURN_HALF);
          cn_q[l][0] <= 1'b1;
        end else if (ph < -e2p_pkg::TURN_QUARTER) begin
          cz_q[l][0] <= AB'(ph + e2p_pkg::TURN_HALF);
          cn_q[l][0] <= 1'b1;
        end else begin
          cz_q[l][0] <= AB'(ph);
          cn_q[l][0] <= 1'b0;
        end
      end
    end

    for (genvar i = 0; i < NCS; i++) begin : g_step
      logic signed [AB-1:0] dx, dy;
      assign dx = cy_q[l][i] >>> i;
      assign dy = cx_q[l][i] >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          cn_q[l][i+1] <= cn_q[l][i];
          if (!cz_q[l][i][AB-1]) begin
            cx_q[l][i+1] <= cx_q[l][i] - dx;
            cy_q[l][i+1] <= cy_q[l][i] + dy;
            cz_q[l][i+1] <= cz_q[l][i] - e2p_pkg::atan_turn(i);
          end else begin
            cx_q[l][i+1] <= cx_q[l][i] + dx;
            cy_q[l][i+1] <= cy_q[l][i] - dy;
            cz_q[l][i+1] <= cz_q[l][i] + e2p_pkg::atan_turn(i);
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sin_q[l] <= cn_q[l][NCS] ? RB'(-cy_q[l][NCS]) : RB'(cy_q[l][NCS]);
        cos_q[l] <= cn_q[l][NCS] ? RB'(-cx_q[l][NCS]) : RB'(cx_q[l][NCS]);
      end
    end
  end

  // ---------------------------------------------------------------- ray and rotation
  logic signed [2*RB-1:0] pxz [2];
  logic signed [RB-1:0]   ray_q [3];
  logic signed [PRB-1:0]  prd_q [3][3];
  logic signed [ROB-1:0]  rot_q [3];

  // Q16 products rounded by adding half and flooring.
  assign pxz[0] = sin_q[0] * cos_q[1] + (2*RB)'(32768);
  assign pxz[1] = cos_q[0] * cos_q[1] + (2*RB)'(32768);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ray_q[0] <= pxz[0][16+RB-1:16];
      ray_q[1] <= sin_q[1];
      ray_q[2] <= pxz[1][16+RB-1:16];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar k = 0; k < 3; k++) begin : g_col
      logic signed [KB-1:0] cf;
      assign cf = $signed(rot_row_q[r][KB*k +: KB]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          prd_q[r][k] <= cf * ray_q[k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rot_q[r] <= ROB'(prd_q[r][0]) + ROB'(prd_q[r][1]) + ROB'(prd_q[r][2]);
      end
    end
  end

  // ---------------------------------------------------------------- projection setup
  logic           pp_front_q, pm_front_q;
  logic [ROB-1:0] pp_mag_q [2];
  logic           pp_neg_q [2];
  logic           pm_neg_q [2];
  logic [ROB-1:0] pp_rz_q, pm_rz_q;
  logic [PMB-1:0] pm_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_front_q <= !rot_q[2][ROB-1] && (rot_q[2] != '0);
      pp_rz_q    <= rot_q[2];
      for (int l = 0; l < 2; l++) begin
        pp_neg_q[l] <= rot_q[l][ROB-1];
        pp_mag_q[l] <= rot_q[l][ROB-1] ? ROB'(-rot_q[l]) : ROB'(rot_q[l]);
      end
      pm_front_q <= pp_front_q;
      pm_rz_q    <= pp_rz_q;
      for (int l = 0; l < 2; l++) begin
        pm_neg_q[l] <= pp_neg_q[l];
        pm_q[l]     <= pp_mag_q[l] * focal_q;
      end
    end
  end

  // ---------------------------------------------------------------- projection divider
  logic [PJ_DW-1:0] pj_rem_q [2][PJ_QB+1];
  logic [PJ_QB-1:0] pj_wrk_q [2][PJ_QB+1];
  logic [PJ_DW-1:0] pj_den_q [2][PJ_QB+1];
  logic             pj_neg_q [2][PJ_QB+1];
  logic             pj_ovf_q [2][PJ_QB+1];
  logic             pj_front_q [PJ_QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pj_front_q[0] <= pm_front_q;
      for (int j = 1; j <= PJ_QB; j++) begin
        pj_front_q[j] <= pj_front_q[j-1];
      end
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_pj_lane
    logic [PJ_NB-1:0] num;
    logic [PJ_DW-1:0] den;
    logic             ovf;
    assign num = {1'b0, pm_q[l], 1'b0} + PJ_NB'(pm_rz_q);
    assign den = pm_front_q ? {pm_rz_q, 1'b0} : PJ_DW'(1);
    // A quotient wider than PJ_QB bits saturates in any case.
    assign ovf = PJ_DW'(num[PJ_NB-1:PJ_QB]) >= den;

    always_ff @(posedge clk_i) begin
      if (en) begin
        pj_rem_q[l][0] <= ovf ? '0 : PJ_DW'(num[PJ_NB-1:PJ_QB]);
        pj_wrk_q[l][0] <= num[PJ_QB-1:0];
        pj_den_q[l][0] <= den;
        pj_neg_q[l][0] <= pm_neg_q[l];
        pj_ovf_q[l][0] <= ovf;
      end
    end

    for (genvar j = 1; j <= PJ_QB; j++) begin : g_step
      logic [PJ_DW:0] t, dif;
      logic           ge;
      assign t   = {pj_rem_q[l][j-1], pj_wrk_q[l][j-1][PJ_QB-1]};
      assign dif = t - {1'b0, pj_den_q[l][j-1]};
      assign ge  = t >= {1'b0, pj_den_q[l][j-1]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          pj_rem_q[l][j] <= ge ? dif[PJ_DW-1:0] : t[PJ_DW-1:0];
          pj_wrk_q[l][j] <= {pj_wrk_q[l][j-1][PJ_QB-2:0], ge};
          pj_den_q[l][j] <= pj_den_q[l][j-1];
          pj_neg_q[l][j] <= pj_neg_q[l][j-1];
          pj_ovf_q[l][j] <= pj_ovf_q[l][j-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- offset and saturate
  logic signed [OB-1:0] res_d [2];
  logic signed [OB-1:0] res_q [2];
  logic                 front_q;

  for (genvar l = 0; l < 2; l++) begin : g_out
    logic signed [SB-1:0] q, off, v;
    assign q   = $signed({2'b00, pj_wrk_q[l][PJ_QB]});
    assign off = $signed(SB'(size[l]) << (e2p_pkg::FRAC_BITS - 1));
    assign v   = off + (pj_neg_q[l][PJ_QB] ? -q : q);
    always_comb begin
      if (!pj_front_q[PJ_QB]) begin
        res_d[l] = '0;
      end else if (pj_ovf_q[l][PJ_QB]) begin
        res_d[l] = pj_neg_q[l][PJ_QB] ? OB'(e2p_pkg::OUT_MIN) : OB'(e2p_pkg::OUT_MAX);
      end else if (v > e2p_pkg::OUT_MAX) begin
        res_d[l] = OB'(e2p_pkg::OUT_MAX);
      end else if (v < e2p_pkg::OUT_MIN) begin
        res_d[l] = OB'(e2p_pkg::OUT_MIN);
      end else begin
        res_d[l] = v[OB-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_q  <= pj_front_q[PJ_QB];
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
    end
  end

  assign m_axis_tvalid   = vld_q[NST-1];
  assign m_axis_tuser[0] = front_q;
  assign m_axis_tdata    = e2p_pkg::OUT_TDATA_BITS'({res_q[1], res_q[0]});

  // ---------------------------------------------------------------- assertions
  `E2P_ASSERT(a_back_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "ray behind but coordinates nonzero")
  `E2P_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_q), "pipeline moved while stalled")
  `E2P_ASSERT_NEXT(a_drain, vld_q[NST-2] && en, m_axis_tvalid, "item lost before output")

endmodule

// ===== test/equirect_to_perspective_map_tb.sv =====
// Self-checking testbench for the equirectangular to perspective coordinate map.
`timescale 1ns / 100ps

module equirect_to_perspective_map_tb;

  typedef struct {
    logic                  in_front;
    logic signed [23:0]    src_x;
    logic signed [23:0]    src_y;
  } src_coord_t;

  typedef struct {
    logic [e2p_pkg::COORD_BITS-1:0] px;
    logic [e2p_pkg::COORD_BITS-1:0] py;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [e2p_pkg::IN_TDATA_BITS-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [e2p_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [e2p_pkg::CFG_IDX_BITS-1:0] cfg_addr_i = e2p_pkg::CFG_IMAGE_WIDTH;
  logic [e2p_pkg::ROW_BITS-1:0] cfg_wdata_i = '0;

  equirect_to_perspective_map uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers.
  longint unsigned width_q, height_q, focal_q;
  logic [e2p_pkg::ROW_BITS-1:0] rot_q[3];

  pixel_t pending_pixels[$];
  src_coord_t expected_coords[$];
  int errors = 0;
  int checked = 0;
  int in_front_seen = 0;
  int behind_seen = 0;
  int saturated_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rx_stall_req = 0;
  int rx_stall_seen = 0;
  int rx_stall_left = 0;

  function automatic int angle_phase(input longint num, input longint den, input int sh);
    longint unsigned mag, q;
    int u;
    mag = (num < 0) ? -num : num;
    q = ((mag << (sh + 1)) + den) / (2 * den);
    u = int'(q & 64'hFFFF);
    if (num < 0) u = (32'h10000 - u) & 32'hFFFF;
    return (u & 32'h8000) ? u - 65536 : u;
  endfunction

  function automatic void cordic_sin_cos(input int ph, output longint s, output longint c);
    logic flip;
    longint x, y, z, dx, dy;
    flip = 1'b0;
    x = e2p_pkg::CORDIC_GAIN_INV;
    y = 0;
    if (ph > e2p_pkg::TURN_QUARTER) begin
      ph -= e2p_pkg::TURN_HALF;
      flip = 1'b1;
    end else if (ph < -e2p_pkg::TURN_QUARTER) begin
      ph += e2p_pkg::TURN_HALF;
      flip = 1'b1;
    end
    z = ph;
    for (int i = 0; i < e2p_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(e2p_pkg::atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(e2p_pkg::atan_turn(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint q16_product(input longint a, input longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic signed [23:0] project_axis(input longint num, input longint den,
                                                      input longint unsigned size);
    logic [63:0] mag, q, d;
    longint v;
    mag = ((num < 0) ? -num : num) * focal_q;
    d = den;
    q = (2 * mag + d) / (2 * d);
    v = (num < 0) ? -longint'(q) : longint'(q);
    v += longint'(size << (e2p_pkg::FRAC_BITS - 1));
    if (v > e2p_pkg::OUT_MAX) v = e2p_pkg::OUT_MAX;
    if (v < e2p_pkg::OUT_MIN) v = e2p_pkg::OUT_MIN;
    return v[23:0];
  endfunction

  function automatic src_coord_t map_pixel(input pixel_t p);
    src_coord_t r;
    longint w, h, slon, clon, slat, clat;
    longint ray[3], rot[3];
    w = (width_q == 0) ? 1 : width_q;
    h = (height_q == 0) ? 1 : height_q;
    cordic_sin_cos(angle_phase(2 * longint'(p.px) - w, w, 15), slon, clon);
    cordic_sin_cos(angle_phase(2 * longint'(p.py) - h, h, 14), slat, clat);
    ray[0] = q16_product(slon, clat);
    ray[1] = slat;
    ray[2] = q16_product(clon, clat);
    for (int row = 0; row < 3; row++) begin
      rot[row] = 0;
      for (int k = 0; k < 3; k++)
        rot[row] += longint'($signed(rot_q[row][e2p_pkg::COEF_BITS*k +: e2p_pkg::COEF_BITS]))
                    * ray[k];
    end
    if (rot[2] <= 0) begin
      r.in_front = 1'b0;
      r.src_x = '0;
      r.src_y = '0;
    end else begin
      r.in_front = 1'b1;
      r.src_x = project_axis(rot[0], rot[2], w);
      r.src_y = project_axis(rot[1], rot[2], h);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  // Sender: holds an item until it is taken, then predicts its result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_coords.push_back(map_pixel('{px: s_axis_tdata[11:0],
                                               py: s_axis_tdata[23:12]}));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_t p;
          p = pending_pixels.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {p.py, p.px};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the stimulus and counted down here.
  always @(posedge clk_i) begin
    if (rx_stall_req != rx_stall_seen) begin
      rx_stall_seen <= rx_stall_req;
      rx_stall_left <= 400;
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_coords.size() == 0) begin
          report_mismatch("unexpected item, tdata low", m_axis_tdata[23:0], 0);
        end else begin
          src_coord_t e;
          e = expected_coords.pop_front();
          if (m_axis_tuser[0] !== e.in_front)
            report_mismatch("in_front", m_axis_tuser[0], e.in_front);
          if ($signed(m_axis_tdata[23:0]) !== e.src_x)
            report_mismatch("source_x", $signed(m_axis_tdata[23:0]), e.src_x);
          if ($signed(m_axis_tdata[47:24]) !== e.src_y)
            report_mismatch("source_y", $signed(m_axis_tdata[47:24]), e.src_y);
          if (e.in_front) in_front_seen++;
          else behind_seen++;
          if (e.src_x == e2p_pkg::OUT_MAX || e.src_x == e2p_pkg::OUT_MIN) saturated_seen++;
          checked++;
        end
      end
      m_axis_tready <= (rx_stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(input e2p_pkg::cfg_idx_e idx,
                           input logic [e2p_pkg::ROW_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      e2p_pkg::CFG_IMAGE_WIDTH:  width_q = val[e2p_pkg::DIM_BITS-1:0];
      e2p_pkg::CFG_IMAGE_HEIGHT: height_q = val[e2p_pkg::DIM_BITS-1:0];
      e2p_pkg::CFG_FOCAL_LENGTH: focal_q = val[e2p_pkg::FOCAL_BITS-1:0];
      e2p_pkg::CFG_ROT_ROW0:     rot_q[0] = val;
      e2p_pkg::CFG_ROT_ROW1:     rot_q[1] = val;
      e2p_pkg::CFG_ROT_ROW2:     rot_q[2] = val;
      default: ;
    endcase
  endtask

  task automatic configure(input int w, input int h, input int f,
                           input logic [e2p_pkg::ROW_BITS-1:0] r0, r1, r2);
    write_reg(e2p_pkg::CFG_IMAGE_WIDTH, e2p_pkg::ROW_BITS'(w));
    write_reg(e2p_pkg::CFG_IMAGE_HEIGHT, e2p_pkg::ROW_BITS'(h));
    write_reg(e2p_pkg::CFG_FOCAL_LENGTH, e2p_pkg::ROW_BITS'(f));
    write_reg(e2p_pkg::CFG_ROT_ROW0, r0);
    write_reg(e2p_pkg::CFG_ROT_ROW1, r1);
    write_reg(e2p_pkg::CFG_ROT_ROW2, r2);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || s_axis_tvalid || expected_coords.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic push_pixel(input int x, input int y);
    pending_pixels.push_back('{px: e2p_pkg::COORD_BITS'(x), py: e2p_pkg::COORD_BITS'(y)});
  endtask

  // Mostly pixels inside the image, some anywhere in the coordinate range.
  task automatic push_random(input int n);
    int w, h;
    w = (width_q == 0) ? 1 : int'(width_q);
    h = (height_q == 0) ? 1 : int'(height_q);
    if (w > 4096) w = 4096;
    if (h > 4096) h = 4096;
    repeat (n) begin
      if ($urandom_range(3) == 0)
        push_pixel($urandom_range(4095), $urandom_range(4095));
      else
        push_pixel($urandom_range(w - 1), $urandom_range(h - 1));
    end
  endtask

  function automatic logic [e2p_pkg::ROW_BITS-1:0] rand_row();
    return {18'($urandom), 18'($urandom), 18'($urandom)};
  endfunction

  // A unit row with the given sign placed at column k, giving signed permutations.
  function automatic logic [e2p_pkg::ROW_BITS-1:0] unit_row(input int k, input logic neg);
    logic [e2p_pkg::ROW_BITS-1:0] r;
    r = '0;
    r[e2p_pkg::COEF_BITS*k +: e2p_pkg::COEF_BITS] = neg ? -e2p_pkg::COEF_ONE
                                                         : e2p_pkg::COEF_ONE;
    return r;
  endfunction

  initial begin
    width_q = e2p_pkg::WIDTH_RESET;
    height_q = e2p_pkg::HEIGHT_RESET;
    focal_q = e2p_pkg::FOCAL_RESET;
    rot_q[0] = unit_row(0, 1'b0);
    rot_q[1] = unit_row(1, 1'b0);
    rot_q[2] = unit_row(2, 1'b0);
    send_idle_pct = 23;
    recv_idle_pct = 84;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: corners, centre, wrap outside the image and the rear hemisphere.
    push_pixel(0, 0);
    push_pixel(4095, 4095);
    push_pixel(512, 256);
    push_pixel(0, 256);
    push_pixel(1023, 256);
    push_pixel(768, 256);
    push_pixel(256, 256);
    push_pixel(512, 0);
    push_pixel(512, 511);
    push_pixel(2048, 1000);
    push_pixel(4095, 0);
    push_pixel(12'hAAA, 12'h555);
    push_pixel(12'h555, 12'hAAA);
    drain();
    // Zero-sized image and the largest focal length, so projections saturate.
    configure(0, 0, 24'hFFFFFF, unit_row(0, 1'b0), unit_row(1, 1'b0), unit_row(2, 1'b0));
    push_pixel(0, 0);
    push_pixel(1, 1);
    push_pixel(4095, 4095);
    drain();
    configure(4096, 4096, 24'hFFFFFF, unit_row(0, 1'b0), unit_row(1, 1'b0),
              unit_row(2, 1'b0));
    push_pixel(2048 + 1000, 2048);
    push_pixel(2048 - 1000, 2048 + 1000);
    push_pixel(2048, 2048);
    push_pixel(2048 + 1023, 2048 - 1023);
    push_pixel(4095, 4095);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      int w, h, f;
      logic [e2p_pkg::ROW_BITS-1:0] r0, r1, r2;
      if (ph == 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 23;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: w = 1;
        1: w = 4096;
        2: w = 0;
        default: w = $urandom_range(1, 4096);
      endcase
      h = (ph == 1) ? 1 : (ph == 0) ? 4096 : $urandom_range(1, 4096);
      f = (ph == 0) ? 0 : (ph == 5) ? 24'hFFFFFF : $urandom_range(24'hFFFFFF);
      if (ph[0]) begin
        r0 = rand_row();
        r1 = rand_row();
        r2 = rand_row();
      end else begin
        r0 = unit_row(0, $urandom_range(1));
        r1 = unit_row(1, $urandom_range(1));
        r2 = unit_row(2, $urandom_range(1));
      end
      if (ph == 7) begin
        r0 = {3{18'h1FFFF}};
        r1 = {3{18'h20000}};
        r2 = {3{18'h3FFFF}};
      end
      configure(w, h, f, r0, r1, r2);
      if (ph == 1) begin
        // Stall the receiver while items keep arriving, so the pipeline backs up.
        push_random(100);
        @(posedge clk_i);
        rx_stall_req <= rx_stall_req + 1;
        push_random(75);
      end else if (ph == 4) begin
        push_random(80);
        drain();
        push_random(95);
      end else begin
        push_random(175);
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("checked %0d results: %0d in front, %0d behind, %0d saturated on x",
             checked, in_front_seen, behind_seen, saturated_seen);
    $display("covered reset, zero-size and extreme registers, random matrices and stalls");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_coords.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
